// ===== rtl/hlfd_pkg.sv =====
// Shared types and constants for the header/length frame deframer.
// No dependencies; imported by the deframer top level and its checker.
package hlfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned HDR_W    = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned M_DATA_W = 48;

    localparam logic [HDR_W-1:0] HEADER_RESET = 32'h4A59_4D43;
    localparam logic [2:0]       WIN_FULL     = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_OPCODE  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

endpackage

// ===== rtl/header_length_frame_deframer.sv =====
// Header/length frame deframer with XOR checksum: one received byte per word.
// Depends on hlfd_pkg (phase and result kind codes, widths, header reset).
//
// Pipeline: an accepted input word is loaded into the input register, and its
//   result into the result register that drives m_*, once that slot is free or draining.
//   Throughput: 1 word per cycle; while a result waits for m_tready the input
//   register takes one more word, then s_tready drops until the result is taken.
// Reset (aresetn low, synchronous): hunting with an empty window, pipeline
//   empty, header_word back to 0x4A594D43.
module header_length_frame_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream: tdata[7:0] rx_byte
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hlfd_pkg::BYTE_W-1:0]   s_tdata,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: [7:0] opcode, [15:8] payload_byte, [31:16] byte_index,
    //        [47:32] frame_length
    output logic [hlfd_pkg::M_DATA_W-1:0] m_tdata,
    // tuser: [1:0] kind
    output logic [hlfd_pkg::KIND_W-1:0]   m_tuser,
    // header_word write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hlfd_pkg::HDR_W-1:0]    cfg_data
);
    import hlfd_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic [HDR_W-1:0]  header_reg;
    logic [HDR_W-1:0]  window_reg, window_next;
    logic [2:0]        fill_reg, fill_next;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] opcode_reg, opcode_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  seen_reg, seen_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    kind_t               m_kind_reg;

    logic                res_valid;
    kind_t               res_kind;
    logic [BYTE_W-1:0]   res_payload;
    logic [LEN_W-1:0]    res_index;

    logic [HDR_W-1:0]  shifted;
    logic              hdr_match;
    logic [LEN_W-1:0]  seen_inc;
    logic              advance;

    // the stored word moves on when the result slot is free or being drained
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign shifted   = {window_reg[HDR_W-BYTE_W-1:0], in_byte_reg};
    assign hdr_match = (fill_reg >= WIN_FULL - 3'd1) && (shifted == header_reg);
    assign seen_inc  = seen_reg + LEN_W'(1);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_OPCODE:  phase_next = PH_LEN_HI;
            PH_LEN_HI:  phase_next = PH_LEN_LO;
            PH_LEN_LO:  phase_next = ({len_reg[LEN_W-1:BYTE_W], in_byte_reg} == '0)
                                     ? PH_CHECK : PH_PAYLOAD;
            PH_PAYLOAD: phase_next = (seen_inc == len_reg) ? PH_CHECK : PH_PAYLOAD;
            PH_CHECK:   phase_next = PH_HUNT;
            default:    phase_next = hdr_match ? PH_OPCODE : PH_HUNT;
        endcase
    end

    // datapath and result
    always_comb begin
        window_next = window_reg;
        fill_next   = fill_reg;
        opcode_next = opcode_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        xor_next    = xor_reg;
        res_valid   = 1'b0;
        res_kind    = KIND_DATA;
        res_payload = '0;
        res_index   = '0;
        case (phase_reg)
            PH_OPCODE: begin
                opcode_next = in_byte_reg;
                xor_next    = xor_reg ^ in_byte_reg;
            end
            PH_LEN_HI: begin
                len_next = {in_byte_reg, BYTE_W'(0)};
                xor_next = xor_reg ^ in_byte_reg;
            end
            PH_LEN_LO: begin
                len_next  = {len_reg[LEN_W-1:BYTE_W], in_byte_reg};
                xor_next  = xor_reg ^ in_byte_reg;
                seen_next = '0;
            end
            PH_PAYLOAD: begin
                res_valid   = 1'b1;
                res_payload = in_byte_reg;
                res_index   = seen_reg;
                xor_next    = xor_reg ^ in_byte_reg;
                seen_next   = seen_inc;
            end
            PH_CHECK: begin
                res_valid   = 1'b1;
                res_kind    = (xor_reg == in_byte_reg) ? KIND_GOOD : KIND_BAD;
                window_next = '0;
                fill_next   = '0;
            end
            default: begin
                window_next = shifted;
                if (fill_reg < WIN_FULL) begin
                    fill_next = fill_reg + 3'd1;
                end
                if (hdr_match) begin
                    xor_next    = shifted[31:24] ^ shifted[23:16]
                                ^ shifted[15:8] ^ shifted[7:0];
                    opcode_next = '0;
                    len_next    = '0;
                    seen_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            header_reg   <= HEADER_RESET;
            window_reg   <= '0;
            fill_reg     <= '0;
            phase_reg    <= PH_HUNT;
            opcode_reg   <= '0;
            len_reg      <= '0;
            seen_reg     <= '0;
            xor_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                header_reg <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= res_valid;
                window_reg  <= window_next;
                fill_reg    <= fill_next;
                phase_reg   <= phase_next;
                opcode_reg  <= opcode_next;
                len_reg     <= len_next;
                seen_reg    <= seen_next;
                xor_reg     <= xor_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            m_kind_reg <= res_kind;
            m_data_reg <= {len_reg, res_index, res_payload, opcode_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule

// ===== rtl/hlfd_checker.sv =====
// Port-level checks for the header/length frame deframer, bound to the top.
// Depends on hlfd_pkg for kind codes and widths.
module hlfd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hlfd_pkg::M_DATA_W-1:0] m_tdata,
    input logic [hlfd_pkg::KIND_W-1:0]   m_tuser
);
    import hlfd_pkg::*;

    // a held result word does not change until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // only the three defined result kinds appear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_DATA) || (m_tuser == KIND_GOOD)
                  || (m_tuser == KIND_BAD))
        else $error("undefined result kind");

    // end-of-frame words carry zero payload and zero index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_DATA) |-> (m_tdata[31:8] == '0))
        else $error("end word with nonzero payload or index");

    // a payload byte index stays below the declared length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DATA) |-> (m_tdata[31:16] < m_tdata[47:32]))
        else $error("payload index beyond declared length");

    // a new result follows an input word that has passed through the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) |=> !m_tvalid || $past(m_tvalid, 2)
            || $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding input word");

endmodule

bind header_length_frame_deframer hlfd_checker u_hlfd_checker (.*);
